FILE: hdl/assert_macros.svh
// Assertion helpers for the file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is applied.
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, switched off while reset is applied.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hdl/swpc_pkg.sv
package swpc_pkg;

  // Sequencer phases, one-hot.
  typedef enum logic [5:0] {
    PH_START   = 6'b000001,
    PH_BOOT    = 6'b000010,
    PH_WATCH   = 6'b000100,
    PH_HOLD    = 6'b001000,
    PH_GAP     = 6'b010000,
    PH_RESTART = 6'b100000
  } phase_t;

  // Phase codes as reported on the result channel.
  localparam logic [2:0] PC_START   = 3'd0;
  localparam logic [2:0] PC_BOOT    = 3'd1;
  localparam logic [2:0] PC_WATCH   = 3'd2;
  localparam logic [2:0] PC_HOLD    = 3'd3;
  localparam logic [2:0] PC_GAP     = 3'd4;
  localparam logic [2:0] PC_RESTART = 3'd5;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REBOOT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS    = 3'd4;

  localparam int unsigned CFG_DATA_W = 32;

  // Register reset values.
  localparam logic [31:0] RST_INTERVAL = 32'd120000;
  localparam logic [31:0] RST_REBOOT   = 32'd120000;
  localparam logic [15:0] RST_HOLD     = 16'd7000;
  localparam logic [15:0] RST_GAP      = 16'd5000;
  localparam logic [15:0] RST_PRESS    = 16'd1000;

  // Restart command matching.
  localparam logic [3:0] CMD_LAST = 4'd11;
  localparam logic [7:0] NEWLINE  = 8'h0A;

  // Byte expected at each position of the restart command.
  function automatic logic [7:0] cmd_byte(input logic [3:0] pos);
    logic [7:0] b;
    case (pos)
      4'd0:    b = 8'h73;
      4'd1:    b = 8'h79;
      4'd2:    b = 8'h73;
      4'd3:    b = 8'h77;
      4'd4:    b = 8'h64;
      4'd5:    b = 8'h74;
      4'd6:    b = 8'h5F;
      4'd7:    b = 8'h72;
      4'd8:    b = 8'h65;
      4'd9:    b = 8'h73;
      4'd10:   b = 8'h65;
      4'd11:   b = 8'h74;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Reported code of a phase.
  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] c;
    unique case (ph)
      PH_START:   c = PC_START;
      PH_BOOT:    c = PC_BOOT;
      PH_WATCH:   c = PC_WATCH;
      PH_HOLD:    c = PC_HOLD;
      PH_GAP:     c = PC_GAP;
      PH_RESTART: c = PC_RESTART;
      default:    c = PC_START;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/swpc_if.sv
// Input channel: one tick or one received byte per transfer.
interface swpc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// Result channel: one result per accepted input item.
interface swpc_out_if;
  logic       valid;
  logic       ready;
  logic       power_switch;
  logic       wait_lamp;
  logic       command_ack;
  logic       expired;
  logic [2:0] phase;

  modport source (output valid, output power_switch, output wait_lamp,
                  output command_ack, output expired, output phase, input ready);
  modport sink   (input valid, input power_switch, input wait_lamp,
                  input command_ack, input expired, input phase, output ready);
endinterface

FILE: hdl/system_watchdog_power_cycler.sv
// Channel   Direction  Payload
// in_ch     in         mode, rx_byte
// out_ch    out        power_switch, wait_lamp, command_ack, expired, phase
// cfg_*     in         cfg_we, cfg_index, cfg_wdata (write only)
//
// Each transfer in produces one result in the following cycle; a new item is taken
// in every cycle, limited only by the single result register.
// The input side stalls only while a result waits and out_ch.ready is low.
// Synchronous active-low reset restores the register defaults, starts the
// power-on press and empties the result register.
`include "assert_macros.svh"

module system_watchdog_power_cycler
  import swpc_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  swpc_in_if.sink              in_ch,
  swpc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned CW    = COUNTER_WIDTH;
  localparam int unsigned CMP_W = (CW > 32) ? CW : 32;

  // Saturating increment of a counter.
  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == {CW{1'b1}}) ? v : v + CW'(1);
  endfunction

  // Configuration registers.
  logic [31:0] interval_r, reboot_r;
  logic [15:0] hold_r, gap_r, press_r;

  // Sequencer and matcher state.
  phase_t        phase_r, phase_nxt;
  logic [CW-1:0] phase_el_r, phase_el_nxt;
  logic [CW-1:0] watch_el_r, watch_el_nxt;
  logic [3:0]    pos_r, pos_nxt;
  logic          spoil_r, spoil_nxt;

  // Result register.
  logic       out_valid_r;
  logic       out_pwr_r, out_lamp_r, out_ack_r, out_exp_r;
  logic [2:0] out_phase_r;

  logic          ack, exp;
  logic [CW-1:0] phase_inc, watch_inc;
  logic [CMP_W-1:0] duration;
  phase_t        phase_after;
  logic          in_acc;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Configuration writes take effect at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= RST_INTERVAL;
      reboot_r   <= RST_REBOOT;
      hold_r     <= RST_HOLD;
      gap_r      <= RST_GAP;
      press_r    <= RST_PRESS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INTERVAL: interval_r <= cfg_wdata;
        CFG_REBOOT:   reboot_r   <= cfg_wdata;
        CFG_HOLD:     hold_r     <= cfg_wdata[15:0];
        CFG_GAP:      gap_r      <= cfg_wdata[15:0];
        CFG_PRESS:    press_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Duration and successor of each timed phase.
  always_comb begin
    unique case (phase_r)
      PH_START: begin
        duration    = CMP_W'(press_r);
        phase_after = PH_BOOT;
      end
      PH_BOOT: begin
        duration    = CMP_W'(reboot_r);
        phase_after = PH_WATCH;
      end
      PH_HOLD: begin
        duration    = CMP_W'(hold_r);
        phase_after = PH_GAP;
      end
      PH_GAP: begin
        duration    = CMP_W'(gap_r);
        phase_after = PH_RESTART;
      end
      PH_RESTART: begin
        duration    = CMP_W'(press_r);
        phase_after = PH_BOOT;
      end
      default: begin
        duration    = '0;
        phase_after = PH_BOOT;
      end
    endcase
  end

  assign phase_inc = sat_inc(phase_el_r);
  assign watch_inc = sat_inc(watch_el_r);

  // Next state for the item on the input channel.
  always_comb begin
    phase_nxt    = phase_r;
    phase_el_nxt = phase_el_r;
    watch_el_nxt = watch_el_r;
    pos_nxt      = pos_r;
    spoil_nxt    = spoil_r;
    ack          = 1'b0;
    exp          = 1'b0;
    if (!in_ch.mode) begin
      if (phase_r == PH_WATCH) begin
        watch_el_nxt = watch_inc;
        if (CMP_W'(watch_inc) > CMP_W'(interval_r)) begin
          exp          = 1'b1;
          phase_nxt    = PH_HOLD;
          phase_el_nxt = '0;
          watch_el_nxt = '0;
        end
      end else begin
        phase_el_nxt = phase_inc;
        if (CMP_W'(phase_inc) >= duration) begin
          phase_nxt    = phase_after;
          phase_el_nxt = '0;
          if (phase_after == PH_WATCH) begin
            watch_el_nxt = '0;
          end
        end
      end
    end else begin
      if (in_ch.rx_byte == NEWLINE) begin
        pos_nxt   = '0;
        spoil_nxt = 1'b0;
      end else if (!spoil_r && pos_r <= CMD_LAST && in_ch.rx_byte == cmd_byte(pos_r)) begin
        if (pos_r == CMD_LAST) begin
          // Whole command seen: restart the watchdog.
          ack          = 1'b1;
          pos_nxt      = '0;
          watch_el_nxt = '0;
        end else begin
          pos_nxt = pos_r + 4'd1;
        end
      end else begin
        spoil_nxt = 1'b1;
        pos_nxt   = '0;
      end
    end
  end

  // State advances on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_START;
      phase_el_r <= '0;
      watch_el_r <= '0;
      pos_r      <= '0;
      spoil_r    <= 1'b0;
    end else if (in_acc) begin
      phase_r    <= phase_nxt;
      phase_el_r <= phase_el_nxt;
      watch_el_r <= watch_el_nxt;
      pos_r      <= pos_nxt;
      spoil_r    <= spoil_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, loaded with each input transfer.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_pwr_r   <= (phase_nxt == PH_START) || (phase_nxt == PH_HOLD) ||
                     (phase_nxt == PH_RESTART);
      out_lamp_r  <= (phase_nxt == PH_BOOT);
      out_ack_r   <= ack;
      out_exp_r   <= exp;
      out_phase_r <= phase_code(phase_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.power_switch = out_pwr_r;
  assign out_ch.wait_lamp    = out_lamp_r;
  assign out_ch.command_ack  = out_ack_r;
  assign out_ch.expired      = out_exp_r;
  assign out_ch.phase        = out_phase_r;

  // Checks on the sequencer and the result register.
  `CHK_SAME(a_no_take_when_full, clk, rst_n, out_valid_r && !out_ch.ready, !in_ch.ready)
  `CHK_SAME(a_expiry_enters_hold, clk, rst_n, out_valid_r && out_exp_r, out_phase_r == PC_HOLD)
  `CHK_SAME(a_ack_not_on_tick, clk, rst_n, out_valid_r, !(out_ack_r && out_exp_r))
  `CHK_NEXT(a_byte_keeps_phase, clk, rst_n, in_acc && in_ch.mode, $stable(phase_r))

endmodule
